[src/rcsl_pkg.sv]
// ----------------------------------------------------------------------------
// rcsl_pkg : shared types, codes and helpers of the archive byte lexer
// token and error codes, keyword table, result word layout, byte classes
// ----------------------------------------------------------------------------
package rcsl_pkg;

  // sizing
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned MAX_WORD        = 128;
  localparam int unsigned HEADER_LIMIT    = 31;
  localparam int unsigned WLEN_W          = 8;
  localparam int unsigned HCNT_W          = 5;
  localparam int unsigned KW_BYTES        = 8;
  localparam int unsigned KW_COUNT        = 18;
  localparam int unsigned MAX_RES         = 3;
  localparam int unsigned N_CAND          = 4;
  localparam int unsigned Q_DEPTH         = 8;
  localparam int unsigned Q_AW            = $clog2(Q_DEPTH);

  // token kinds
  localparam logic [2:0] TK_EOF   = 3'd0;
  localparam logic [2:0] TK_SEMI  = 3'd1;
  localparam logic [2:0] TK_COLON = 3'd2;
  localparam logic [2:0] TK_BLOCK = 3'd3;
  localparam logic [2:0] TK_COMMA = 3'd4;
  localparam logic [2:0] TK_WORD  = 3'd5;
  localparam logic [2:0] TK_REV   = 3'd6;
  localparam logic [2:0] TK_ERR   = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OPEN = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  localparam logic [4:0] KW_NONE = 5'd0;

  // byte values
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] LINE_MAX = 32'hffff_ffff;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h7365_6863_6e61_7262,  // branches
    64'h0073_6c6f_626d_7973,  // symbols
    64'h0074_6e65_6d6d_6f63,  // comment
    64'h0000_7463_6972_7473,  // strict
    64'h0000_6863_6e61_7262,  // branch
    64'h0000_726f_6874_7561,  // author
    64'h0000_7373_6563_6361,  // access
    64'h0000_646e_6170_7865,  // expand
    64'h0000_7461_6d72_6f66,  // format
    64'h0000_0065_7461_7473,  // state
    64'h0000_0073_6b63_6f6c,  // locks
    64'h0000_0000_7478_6574,  // text
    64'h0000_0000_7478_656e,  // next
    64'h0000_0000_6461_6568,  // head
    64'h0000_0000_6373_6564,  // desc
    64'h0000_0000_6574_6164,  // date
    64'h0000_0000_0074_7865,  // ext
    64'h0000_0000_0067_6f6c   // log
  };

  localparam logic [WLEN_W-1:0] KW_LEN [KW_COUNT] = '{
    8'd8, 8'd7, 8'd7, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd3, 8'd3
  };

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [4:0]  keyword_id;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic        has_doubled_at;
    logic [31:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // up to four candidate results of one byte, in emission order
  typedef struct packed {
    result_t [N_CAND-1:0] res;
    logic [N_CAND-1:0]    vld;
  } push_t;

  function automatic logic is_white(input logic [7:0] c);
    return ((c >= CH_BS) && (c <= CH_CR)) || (c == CH_SP);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_revch(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_white(c) || (c == CH_COLON) || (c == CH_SEMI) || (c == CH_AT);
  endfunction

  function automatic logic [31:0] line_inc(input logic [31:0] l);
    return (l == LINE_MAX) ? l : l + 32'd1;
  endfunction

  // first match in table order wins
  function automatic logic [4:0] kw_lookup(input logic [63:0] win,
                                           input logic [WLEN_W-1:0] len);
    logic [4:0] id;
    id = KW_NONE;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if ((KW_LEN[i] == len) && (KW_TEXT[i] == win)) id = 5'(i + 1);
    end
    return id;
  endfunction

  function automatic result_t mk_res(input logic [2:0] kind, input logic [4:0] kw,
                                     input logic [31:0] start, input logic [31:0] len,
                                     input logic dbl, input logic [31:0] line_no,
                                     input logic [1:0] err);
    result_t r;
    r.token_kind     = kind;
    r.keyword_id     = kw;
    r.start_offset   = start;
    r.token_length   = len;
    r.has_doubled_at = dbl;
    r.line_number    = line_no;
    r.error_code     = err;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // word or revision token from the word state
  function automatic result_t word_res(input logic [31:0] start,
                                       input logic [WLEN_W-1:0] len,
                                       input logic numeric, input logic [63:0] win,
                                       input logic [31:0] line_no);
    if (numeric) return mk_res(TK_REV, KW_NONE, start, 32'(len), 1'b0, line_no, ERR_NONE);
    return mk_res(TK_WORD, kw_lookup(win, len), start, 32'(len), 1'b0, line_no, ERR_NONE);
  endfunction

endpackage

[src/rcsl_lexer.sv]
// ----------------------------------------------------------------------------
// rcsl_lexer : mode machine and counters of the archive byte lexer
// takes one byte per enabled cycle, updates state, offers up to three results
// ----------------------------------------------------------------------------
module rcsl_lexer #(
  parameter int unsigned OFFSET_BITS = rcsl_pkg::OFFSET_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [7:0]      step_byte,
  input  logic            step_eos,
  output rcsl_pkg::push_t cand
);
  import rcsl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_QUOTE, M_QAT, M_HNUM, M_HREST, M_SKIP, M_HALT
  } mode_t;

  mode_t                   mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [31:0]             line_r, line_nxt;
  logic [OFFSET_BITS-1:0]  tstart_r, tstart_nxt;
  logic [WLEN_W-1:0]       wlen_r, wlen_nxt;
  logic                    allnum_r, allnum_nxt;
  logic [63:0]             kwin_r, kwin_nxt;
  logic                    dbl_r, dbl_nxt;
  logic [31:0]             hval_r, hval_nxt;
  logic [HCNT_W-1:0]       hcnt_r, hcnt_nxt;
  logic [31:0]             skip_r, skip_nxt;

  logic                    do_idle;
  logic                    halt_v;
  logic [35:0]             prod;
  logic [OFFSET_BITS-1:0]  close_v;
  logic [N_CAND-1:0]       raw_vld;
  result_t [N_CAND-1:0]    raw_res;

  function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] p);
    return (&p) ? p : p + 1'b1;
  endfunction

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    wlen_nxt   = wlen_r;
    allnum_nxt = allnum_r;
    kwin_nxt   = kwin_r;
    dbl_nxt    = dbl_r;
    hval_nxt   = hval_r;
    hcnt_nxt   = hcnt_r;
    skip_nxt   = skip_r;
    do_idle    = 1'b0;
    halt_v     = 1'b0;
    raw_vld    = '0;
    raw_res    = '0;
    close_v    = '0;
    prod       = {1'b0, hval_r, 3'b0} + {3'b0, hval_r, 1'b0} + 36'(step_byte - CH_ZERO);

    // slot 0: token closed by this byte, or an error for an over-long word
    case (mode_r)
      M_IDLE: begin
        do_idle = 1'b1;
      end
      M_WORD: begin
        if (is_delim(step_byte)) begin
          raw_vld[0] = 1'b1;
          raw_res[0] = word_res(32'(tstart_r), wlen_r, allnum_r, kwin_r, line_r);
          mode_nxt   = M_IDLE;
          do_idle    = 1'b1;
        end else if (wlen_r >= WLEN_W'(MAX_WORD)) begin
          raw_vld[0] = 1'b1;
          raw_res[0] = mk_res(TK_ERR, KW_NONE, 32'(tstart_r), 32'd0, 1'b0, line_r, ERR_LONG);
          mode_nxt   = M_HALT;
        end else begin
          if (!is_revch(step_byte)) allnum_nxt = 1'b0;
          if (wlen_r < WLEN_W'(KW_BYTES)) kwin_nxt[{wlen_r[2:0], 3'b000} +: 8] = step_byte;
          wlen_nxt = wlen_r + 1'b1;
        end
      end
      M_QUOTE: begin
        if (step_byte == CH_AT) mode_nxt = M_QAT;
        else if (step_byte == CH_LF) line_nxt = line_inc(line_r);
      end
      M_QAT: begin
        if (step_byte == CH_AT) begin
          dbl_nxt  = 1'b1;
          mode_nxt = M_QUOTE;
        end else begin
          close_v    = pos_r - 1'b1;
          raw_vld[0] = 1'b1;
          raw_res[0] = mk_res(TK_BLOCK, KW_NONE, 32'(tstart_r),
                              32'((close_v >= tstart_r) ? close_v - tstart_r : '0),
                              dbl_r, line_r, ERR_NONE);
          mode_nxt   = M_IDLE;
          do_idle    = 1'b1;
        end
      end
      M_HNUM, M_HREST: begin
        hcnt_nxt = hcnt_r + 1'b1;
        if ((mode_r == M_HNUM) && is_digit(step_byte)) begin
          hval_nxt = (|prod[35:32]) ? LINE_MAX : prod[31:0];
        end else begin
          mode_nxt = M_HREST;
        end
        if ((step_byte == CH_LF) || (hcnt_nxt >= HCNT_W'(HEADER_LIMIT))) begin
          tstart_nxt = pos_inc(pos_r);
          raw_vld[0] = 1'b1;
          raw_res[0] = mk_res(TK_BLOCK, KW_NONE, 32'(tstart_nxt), hval_nxt, 1'b0,
                              line_r, ERR_NONE);
          skip_nxt   = hval_nxt;
          mode_nxt   = (hval_nxt != '0) ? M_SKIP : M_IDLE;
        end
      end
      M_SKIP: begin
        skip_nxt = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
        if (skip_nxt == '0) mode_nxt = M_IDLE;
      end
      default: begin
      end
    endcase

    // slot 1: byte seen between tokens
    if (do_idle) begin
      if (is_white(step_byte)) begin
        if (step_byte == CH_LF) line_nxt = line_inc(line_r);
      end else begin
        case (step_byte)
          CH_SEMI: begin
            raw_vld[1] = 1'b1;
            raw_res[1] = mk_res(TK_SEMI, KW_NONE, 32'(pos_r), 32'd1, 1'b0, line_r, ERR_NONE);
          end
          CH_COLON: begin
            raw_vld[1] = 1'b1;
            raw_res[1] = mk_res(TK_COLON, KW_NONE, 32'(pos_r), 32'd1, 1'b0, line_r, ERR_NONE);
          end
          CH_COMMA: begin
            raw_vld[1] = 1'b1;
            raw_res[1] = mk_res(TK_COMMA, KW_NONE, 32'(pos_r), 32'd1, 1'b0, line_r, ERR_NONE);
          end
          CH_AT: begin
            mode_nxt   = M_QUOTE;
            tstart_nxt = pos_inc(pos_r);
            dbl_nxt    = 1'b0;
          end
          CH_PCT: begin
            mode_nxt = M_HNUM;
            hval_nxt = '0;
            hcnt_nxt = '0;
          end
          default: begin
            mode_nxt   = M_WORD;
            tstart_nxt = pos_r;
            wlen_nxt   = WLEN_W'(1);
            allnum_nxt = is_revch(step_byte);
            kwin_nxt   = {56'b0, step_byte};
          end
        endcase
      end
    end

    // slots 2 and 3: end of stream
    if (step_eos) begin
      case (mode_nxt)
        M_WORD: begin
          raw_vld[2] = 1'b1;
          raw_res[2] = word_res(32'(tstart_nxt), wlen_nxt, allnum_nxt, kwin_nxt, line_nxt);
        end
        M_QAT: begin
          raw_vld[2] = 1'b1;
          raw_res[2] = mk_res(TK_BLOCK, KW_NONE, 32'(tstart_nxt),
                              32'((pos_r >= tstart_nxt) ? pos_r - tstart_nxt : '0),
                              dbl_nxt, line_nxt, ERR_NONE);
        end
        M_QUOTE, M_HNUM, M_HREST, M_SKIP: begin
          raw_vld[2] = 1'b1;
          raw_res[2] = mk_res(TK_ERR, KW_NONE, 32'(tstart_nxt), 32'd0, 1'b0, line_nxt,
                              ERR_OPEN);
          halt_v     = 1'b1;
        end
        M_HALT: begin
          halt_v = 1'b1;
        end
        default: begin
        end
      endcase
      if (!halt_v) begin
        raw_vld[3] = 1'b1;
        raw_res[3] = mk_res(TK_EOF, KW_NONE, 32'(pos_inc(pos_r)), 32'd0, 1'b0, line_nxt,
                            ERR_NONE);
      end
      // next file starts from scratch
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      line_nxt   = 32'd1;
      tstart_nxt = '0;
      wlen_nxt   = '0;
      allnum_nxt = 1'b1;
      kwin_nxt   = '0;
      dbl_nxt    = 1'b0;
      hval_nxt   = '0;
      hcnt_nxt   = '0;
      skip_nxt   = '0;
    end else begin
      pos_nxt = pos_inc(pos_r);
    end
  end

  // mark the last result of the byte and gate with the step
  always_comb begin
    cand.res = raw_res;
    cand.vld = raw_vld & {N_CAND{step_en}};
    for (int i = 0; i < N_CAND; i++) begin
      cand.res[i].last_of_run = raw_vld[i] && ((raw_vld >> (i + 1)) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= 32'd1;
      tstart_r <= '0;
      wlen_r   <= '0;
      allnum_r <= 1'b1;
      kwin_r   <= '0;
      dbl_r    <= 1'b0;
      hval_r   <= '0;
      hcnt_r   <= '0;
      skip_r   <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      wlen_r   <= wlen_nxt;
      allnum_r <= allnum_nxt;
      kwin_r   <= kwin_nxt;
      dbl_r    <= dbl_nxt;
      hval_r   <= hval_nxt;
      hcnt_r   <= hcnt_nxt;
      skip_r   <= skip_nxt;
    end
  end

  a_max_res: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cand.vld) <= MAX_RES)
    else $error("more than three results from one byte");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (mode_r == M_HALT) && !step_eos) |-> (cand.vld == '0))
    else $error("result emitted while halted");

  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_eos) |=> ((mode_r == M_IDLE) && (pos_r == '0) && (line_r == 32'd1)))
    else $error("state not back to reset after end of stream");

endmodule

[src/rcsl_queue.sv]
// ----------------------------------------------------------------------------
// rcsl_queue : result queue of the archive byte lexer
// takes up to four ordered results per cycle, hands out, unless stalled, one word per cycle
// ----------------------------------------------------------------------------
module rcsl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  rcsl_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rcsl_pkg::result_t head_o
);
  import rcsl_pkg::*;

  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  result_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] waddr [N_CAND];
  logic [CW-1:0]   npush;
  logic            pop;

  // packed write positions for the valid results
  always_comb begin
    npush = '0;
    for (int i = 0; i < N_CAND; i++) begin
      waddr[i] = wr_r + npush[Q_AW-1:0];
      npush    = npush + CW'(push_i.vld[i]);
    end
  end

  assign pop         = (cnt_r != '0) && !out_stall_i;
  assign out_valid_o = (cnt_r != '0);
  assign head_o      = mem_r[rd_r];
  assign room_o      = (cnt_r <= CW'(Q_DEPTH - MAX_RES));
  assign wr_nxt      = wr_r + npush[Q_AW-1:0];
  assign rd_nxt      = rd_r + Q_AW'(pop);
  assign cnt_nxt     = cnt_r + npush - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_CAND; i++) begin
      if (push_i.vld[i]) mem_r[waddr[i]] <= push_i.res[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.vld != '0) |-> (cnt_r <= CW'(Q_DEPTH - MAX_RES)))
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(Q_DEPTH)) && (cnt_r[Q_AW-1:0] == (wr_r - rd_r)))
    else $error("queue fill count out of step with pointers");

endmodule

[src/rcs_archive_byte_lexer_core.sv]
// ----------------------------------------------------------------------------
// rcs_archive_byte_lexer_core : tokeniser for revision archive files
// one file byte per input word, tokens with offsets and line numbers out
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | in        | in_valid / in_stall   | byte_in, end_of_stream
//  out_    | out       | out_valid / out_stall | token_kind .. last_of_run
//
//  one byte per cycle while in_stall is low; a byte gives zero to three tokens, and
//    tokens leave at one per cycle, unless out_stall is high, through an eight-entry queue
//  a byte passes the input register, then the queue, before its first token can be taken
//  the input register holds its byte while the queue has fewer than three
//    free entries, and in_stall is raised for that long
//  reset (rst_n low at a clock edge) empties the queue and the input
//    register and puts the lexer between tokens, line one, offset zero
//  end of stream returns the lexer to the reset state for the next file
//
module rcs_archive_byte_lexer_core #(
  parameter int unsigned OFFSET_BITS = rcsl_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_stream,
  // token output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [4:0]  out_keyword_id,
  output logic [31:0] out_start_offset,
  output logic [31:0] out_token_length,
  output logic        out_has_doubled_at,
  output logic [31:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);
  import rcsl_pkg::*;

  // input register
  logic       ir_valid_r, ir_valid_nxt;
  logic [7:0] ir_byte_r, ir_byte_nxt;
  logic       ir_eos_r, ir_eos_nxt;

  logic    accept;
  logic    advance;
  logic    room;
  push_t   cand;
  result_t head;

  // the byte in the register is lexed once the queue can take all its tokens
  assign advance  = ir_valid_r && room;
  assign in_stall = ir_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  assign ir_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : ir_valid_r);
  assign ir_byte_nxt  = accept ? in_byte_in : ir_byte_r;
  assign ir_eos_nxt   = accept ? in_end_of_stream : ir_eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else begin
      ir_valid_r <= ir_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    ir_byte_r <= ir_byte_nxt;
    ir_eos_r  <= ir_eos_nxt;
  end

  // mode machine, counters and keyword match
  rcsl_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_byte (ir_byte_r),
    .step_eos  (ir_eos_r),
    .cand      (cand)
  );

  // token queue, doubles as the output register
  rcsl_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (cand),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .head_o      (head)
  );

  assign out_token_kind     = head.token_kind;
  assign out_keyword_id     = head.keyword_id;
  assign out_start_offset   = head.start_offset;
  assign out_token_length   = head.token_length;
  assign out_has_doubled_at = head.has_doubled_at;
  assign out_line_number    = head.line_number;
  assign out_error_code     = head.error_code;
  assign out_last_of_run    = head.last_of_run;

endmodule
